// File: rtl/core/soe_pkg.sv
// Shared types and constants of the shutter OOK pulse encoder.
`timescale 1ns / 1ps
package soe_pkg;

  localparam int unsigned CfgW    = 39;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned IdxW    = 3;
  localparam int unsigned DirW    = 2;
  localparam int unsigned TickW   = 14;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgCodeA    = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgCodeB    = 4'd1;
  localparam logic [CfgIdxW-1:0] CfgCodeC    = 4'd2;
  localparam logic [CfgIdxW-1:0] CfgCodeD    = 4'd3;
  localparam logic [CfgIdxW-1:0] CfgCmdMask  = 4'd4;
  localparam logic [CfgIdxW-1:0] CfgCodeUp   = 4'd5;
  localparam logic [CfgIdxW-1:0] CfgCodeStop = 4'd6;
  localparam logic [CfgIdxW-1:0] CfgCodeDown = 4'd7;

  // Direction codes
  localparam logic [DirW-1:0] DirUp   = 2'd0;
  localparam logic [DirW-1:0] DirStop = 2'd1;
  localparam logic [DirW-1:0] DirDown = 2'd2;
  localparam logic [DirW-1:0] DirBad  = 2'd3;

  // Pulse half lengths in microseconds
  localparam logic [TickW-1:0] PreHigh   = 14'd688;
  localparam logic [TickW-1:0] PreLow    = 14'd10143;
  localparam logic [TickW-1:0] SyncHigh  = 14'd4769;
  localparam logic [TickW-1:0] SyncLow   = 14'd1538;
  localparam logic [TickW-1:0] OneHigh   = 14'd687;
  localparam logic [TickW-1:0] OneLow    = 14'd394;
  localparam logic [TickW-1:0] ZeroHigh  = 14'd328;
  localparam logic [TickW-1:0] ZeroLow   = 14'd756;

  typedef struct packed {
    logic            cmd;
    logic [IdxW-1:0] shutter_index;
    logic [DirW-1:0] direction;
  } in_t;

  typedef struct packed {
    logic tx_level;
    logic busy_res;
    logic rejected;
  } out_t;

endpackage

// File: rtl/core/soe_regs.sv
// Configuration registers and frame word composition.
`timescale 1ns / 1ps
module soe_regs #(
  parameter int unsigned FRAME_BITS = 39
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  logic [soe_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [soe_pkg::CfgW-1:0] cfg_data_i,
  input  soe_pkg::in_t             in_data_i,
  output logic [FRAME_BITS-1:0]    word_o
);
  import soe_pkg::*;

  logic [CfgW-1:0] shutter_q [4];
  logic [CfgW-1:0] mask_q, up_q, stop_q, down_q;
  logic [CfgW-1:0] base, dir_code, merged;
  logic [CfgW+FRAME_BITS-1:0] merged_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) shutter_q[i] <= '0;
      mask_q <= '0;
      up_q   <= '0;
      stop_q <= '0;
      down_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i) inside
        CfgCodeA, CfgCodeB, CfgCodeC, CfgCodeD: shutter_q[cfg_index_i[1:0]] <= cfg_data_i;
        CfgCmdMask:  mask_q <= cfg_data_i;
        CfgCodeUp:   up_q   <= cfg_data_i;
        CfgCodeStop: stop_q <= cfg_data_i;
        CfgCodeDown: down_q <= cfg_data_i;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_comb begin
    base = shutter_q[in_data_i.shutter_index[1:0]];
    case (in_data_i.direction)
      DirUp:   dir_code = up_q;
      DirStop: dir_code = stop_q;
      DirDown: dir_code = down_q;
      default: dir_code = '0;
    endcase
    merged     = (base & ~mask_q) | dir_code;
    merged_ext = {{FRAME_BITS{1'b0}}, merged};
    word_o     = merged_ext[FRAME_BITS-1:0];
  end

endmodule

// File: rtl/core/soe_seq.sv
// Pulse sequencer: frame segments, bit and repeat counters, microsecond timer.
`timescale 1ns / 1ps
module soe_seq #(
  parameter int unsigned NUM_SHUTTERS = 4,
  parameter int unsigned FRAME_BITS   = 39,
  parameter int unsigned REPEAT_COUNT = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  soe_pkg::in_t          in_data_i,
  input  logic [FRAME_BITS-1:0] word_i,
  output soe_pkg::out_t         res_o
);
  import soe_pkg::*;

  localparam int unsigned BlW     = $clog2(FRAME_BITS + 1);
  localparam int unsigned BitIdxW = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;
  localparam int unsigned RepW    = (REPEAT_COUNT > 1) ? $clog2(REPEAT_COUNT) : 1;

  localparam logic [2:0] SegIdle  = 3'd0;
  localparam logic [2:0] SegPre   = 3'd1;
  localparam logic [2:0] SegSync  = 3'd2;
  localparam logic [2:0] SegBits  = 3'd3;
  localparam logic [2:0] SegTrail = 3'd4;

  logic [FRAME_BITS-1:0] frame_q, frame_d;
  logic [BlW-1:0]        bit_left_q, bit_left_d, bl_dec;
  logic [RepW-1:0]       rep_q, rep_d;
  logic [2:0]            seg_q, seg_d;
  logic                  high_q, high_d;
  logic [TickW-1:0]      ticks_q, ticks_d, tick_dec;
  logic                  busy, bad_cmd, cur_bit, next_bit;

  always_comb begin
    frame_d    = frame_q;
    bit_left_d = bit_left_q;
    rep_d      = rep_q;
    seg_d      = seg_q;
    high_d     = high_q;
    ticks_d    = ticks_q;
    res_o      = '0;

    busy     = (seg_q != SegIdle);
    bad_cmd  = (32'(in_data_i.shutter_index) >= NUM_SHUTTERS)
               || (in_data_i.direction == DirBad);
    cur_bit  = frame_q[BitIdxW'(bit_left_q - 1'b1)];
    tick_dec = (ticks_q != '0) ? ticks_q - 1'b1 : '0;
    bl_dec   = (bit_left_q != '0) ? bit_left_q - 1'b1 : '0;
    next_bit = frame_q[BitIdxW'(bl_dec - 1'b1)];

    if (step_i) begin
      if (in_data_i.cmd) begin
        if (busy || bad_cmd) begin
          // Drop the request, keep the pin level
          res_o.rejected = 1'b1;
          res_o.tx_level = busy & high_q;
        end else begin
          frame_d        = word_i;
          bit_left_d     = '0;
          rep_d          = RepW'(REPEAT_COUNT - 1);
          seg_d          = SegPre;
          high_d         = 1'b1;
          ticks_d        = PreHigh;
          res_o.tx_level = 1'b1;
        end
      end else if (busy) begin
        res_o.tx_level = high_q;
        ticks_d        = tick_dec;
        if (tick_dec == '0) begin
          if (high_q) begin
            high_d = 1'b0;
            unique case (seg_q)
              SegSync: ticks_d = SyncLow;
              SegBits: ticks_d = cur_bit ? OneLow : ZeroLow;
              default: ticks_d = PreLow;
            endcase
          end else begin
            high_d = 1'b1;
            unique case (seg_q)
              SegPre: begin
                seg_d   = SegSync;
                ticks_d = SyncHigh;
              end
              SegSync: begin
                seg_d      = SegBits;
                bit_left_d = BlW'(FRAME_BITS);
                ticks_d    = frame_q[FRAME_BITS-1] ? OneHigh : ZeroHigh;
              end
              SegBits: begin
                bit_left_d = bl_dec;
                if (bl_dec != '0) begin
                  ticks_d = next_bit ? OneHigh : ZeroHigh;
                end else begin
                  seg_d   = SegTrail;
                  ticks_d = PreHigh;
                end
              end
              default: begin
                if (rep_q != '0) begin
                  rep_d   = rep_q - 1'b1;
                  seg_d   = SegPre;
                  ticks_d = PreHigh;
                end else begin
                  seg_d      = SegIdle;
                  high_d     = 1'b0;
                  ticks_d    = '0;
                  bit_left_d = '0;
                end
              end
            endcase
          end
        end
      end
    end
    res_o.busy_res = (seg_d != SegIdle);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q    <= '0;
      bit_left_q <= '0;
      rep_q      <= '0;
      seg_q      <= SegIdle;
      high_q     <= 1'b0;
      ticks_q    <= '0;
    end else begin
      frame_q    <= frame_d;
      bit_left_q <= bit_left_d;
      rep_q      <= rep_d;
      seg_q      <= seg_d;
      high_q     <= high_d;
      ticks_q    <= ticks_d;
    end
  end

endmodule

// File: rtl/core/shutter_ook_pulse_encoder_unit.sv
// A result is registered and valid in the cycle after its request is accepted.
// Throughput: one request per cycle unless the output stalls; the sequencer state settles in the accept cycle.
// The output register frees in the cycle it is taken, so requests flow back to back.
// Reset: asynchronous, clears the configuration registers to zero and the
// sequencer to idle; no clearing pass, requests are taken right after reset.
`timescale 1ns / 1ps
module shutter_ook_pulse_encoder_unit #(
  parameter int unsigned NUM_SHUTTERS = 4,
  parameter int unsigned FRAME_BITS   = 39,
  parameter int unsigned REPEAT_COUNT = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  soe_pkg::in_t                in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output soe_pkg::out_t               out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [soe_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [soe_pkg::CfgW-1:0]    cfg_data_i
);
  import soe_pkg::*;

  logic                  accept;
  logic [FRAME_BITS-1:0] word;
  out_t                  res;
  logic                  out_valid_q;
  out_t                  out_data_q;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  soe_regs #(
    .FRAME_BITS(FRAME_BITS)
  ) u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .word_o     (word)
  );

  soe_seq #(
    .NUM_SHUTTERS(NUM_SHUTTERS),
    .FRAME_BITS  (FRAME_BITS),
    .REPEAT_COUNT(REPEAT_COUNT)
  ) u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (accept),
    .in_data_i(in_data_i),
    .word_i   (word),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: rtl/core/soe_checker.sv
// Port-level checker for the shutter OOK pulse encoder and its bind.
`timescale 1ns / 1ps
module soe_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input soe_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input soe_pkg::out_t out_data_o
);
  import soe_pkg::*;

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted request gave no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !in_data_i.cmd |=> !out_data_o.rejected)
    else $error("tick flagged as rejected");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.cmd && in_data_i.direction == DirBad
    |=> out_data_o.rejected)
    else $error("bad direction not rejected");

endmodule

bind shutter_ook_pulse_encoder_unit soe_checker u_soe_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
